// ===== hw/rtl/angle_complementary_filter_assert.svh =====
// ----------------------------------------------------------------------------
// angle_complementary_filter_assert.svh
// assertion macros shared by the filter rtl, clocked on clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef ANGLE_COMPLEMENTARY_FILTER_ASSERT_SVH
`define ANGLE_COMPLEMENTARY_FILTER_ASSERT_SVH

// same-cycle implication
`define ACF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acf: same-cycle check failed");

// next-cycle implication
`define ACF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acf: next-cycle check failed");

`endif

// ===== hw/rtl/acf_pkg.sv =====
// ----------------------------------------------------------------------------
// acf_pkg
// types, constants and fixed-point helpers for the angle complementary filter
// ----------------------------------------------------------------------------
package acf_pkg;

  localparam int ANG_W  = 16;  // q3.12 angle / rate
  localparam int MEAS_W = 17;  // measurement after 2 pi shift
  localparam int PROD_W = 36;  // product or product sum with headroom
  localparam int WIDE_W = 22;  // rounded intermediate angles

  localparam logic signed [WIDE_W-1:0] Q_PI     = 22'sd12868;
  localparam logic signed [WIDE_W-1:0] Q_TWO_PI = 22'sd25736;
  localparam logic signed [WIDE_W-1:0] SAT_MAX  = 22'sd32767;
  localparam logic signed [WIDE_W-1:0] SAT_MIN  = -22'sd32768;
  localparam logic signed [PROD_W-1:0] RND_BIAS = 36'sd32768;

  // commands
  localparam logic [1:0] CMD_PREDICT = 2'd0;
  localparam logic [1:0] CMD_FUSE    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_TIME_STEP  = 2'd0;
  localparam logic [1:0] REG_GYRO_WT    = 2'd1;
  localparam logic [1:0] REG_MEAS_WT    = 2'd2;
  localparam logic [1:0] REG_WRAP_EN    = 2'd3;

  localparam logic [15:0] RST_TIME_STEP = 16'd655;
  localparam logic [15:0] RST_GYRO_WT   = 16'd63570;
  localparam logic [15:0] RST_MEAS_WT   = 16'd1966;
  localparam logic        RST_WRAP_EN   = 1'b1;

  typedef struct packed {
    logic [15:0] time_step;
    logic [15:0] gyro_weight;
    logic [15:0] measure_weight;
    logic        wrap_enable;
  } acf_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_PRED,
    ST_GYRO,
    ST_MEAS,
    ST_BLEND
  } acf_state_t;

  typedef enum logic [1:0] {
    MUL_RATE,
    MUL_GYRO,
    MUL_MEAS
  } acf_mul_sel_t;

  typedef enum logic {
    RES_PRED,
    RES_BLEND
  } acf_res_sel_t;

  typedef struct packed {
    logic         load_in;
    logic         mul_en;
    acf_mul_sel_t mul_sel;
    logic         acc_load;
    logic         pred_load;
    logic         res_load;
    acf_res_sel_t res_sel;
  } acf_cmd_t;

  typedef struct packed {
    logic             is_fuse;
    logic [ANG_W-1:0] estimate;
  } acf_status_t;

  // round half up from q.28 to q.12
  function automatic logic signed [WIDE_W-1:0] round_q12(
    input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    begin
      b = p + RND_BIAS;
      return {{(WIDE_W-(PROD_W-16)){b[PROD_W-1]}}, b[PROD_W-1:16]};
    end
  endfunction

  // one wrap step into [-pi, pi]
  function automatic logic signed [WIDE_W-1:0] wrap_once(
    input logic signed [WIDE_W-1:0] v, input logic en);
    logic signed [WIDE_W-1:0] r;
    begin
      r = v;
      if (en && (v < -Q_PI)) begin
        r = v + Q_TWO_PI;
      end else if (en && (v > Q_PI)) begin
        r = v - Q_TWO_PI;
      end
      return r;
    end
  endfunction

  function automatic logic signed [ANG_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [ANG_W-1:0] r;
    begin
      if (v > SAT_MAX) begin
        r = 16'sh7FFF;
      end else if (v < SAT_MIN) begin
        r = 16'sh8000;
      end else begin
        r = v[ANG_W-1:0];
      end
      return r;
    end
  endfunction

  // pull the measurement within pi of the prediction
  function automatic logic signed [MEAS_W-1:0] meas_adjust(
    input logic signed [ANG_W-1:0] meas, input logic signed [ANG_W-1:0] pred,
    input logic en);
    logic signed [WIDE_W-1:0] m;
    logic signed [WIDE_W-1:0] d;
    logic signed [WIDE_W-1:0] r;
    begin
      m = {{(WIDE_W-ANG_W){meas[ANG_W-1]}}, meas};
      d = m - {{(WIDE_W-ANG_W){pred[ANG_W-1]}}, pred};
      r = m;
      if (en && (d > Q_PI)) begin
        r = m - Q_TWO_PI;
      end else if (en && (d < -Q_PI)) begin
        r = m + Q_TWO_PI;
      end
      return r[MEAS_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/acf_regs.sv =====
// ----------------------------------------------------------------------------
// acf_regs
// apb configuration registers of the angle complementary filter
// ----------------------------------------------------------------------------
module acf_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output acf_pkg::acf_cfg_t  cfg
);

  acf_pkg::acf_cfg_t cfg_r;
  acf_pkg::acf_cfg_t cfg_nxt;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        acf_pkg::REG_TIME_STEP: cfg_nxt.time_step      = cfg_pwdata[15:0];
        acf_pkg::REG_GYRO_WT:   cfg_nxt.gyro_weight    = cfg_pwdata[15:0];
        acf_pkg::REG_MEAS_WT:   cfg_nxt.measure_weight = cfg_pwdata[15:0];
        acf_pkg::REG_WRAP_EN:   cfg_nxt.wrap_enable    = cfg_pwdata[0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_step      <= acf_pkg::RST_TIME_STEP;
      cfg_r.gyro_weight    <= acf_pkg::RST_GYRO_WT;
      cfg_r.measure_weight <= acf_pkg::RST_MEAS_WT;
      cfg_r.wrap_enable    <= acf_pkg::RST_WRAP_EN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      acf_pkg::REG_TIME_STEP: cfg_prdata = {16'd0, cfg_r.time_step};
      acf_pkg::REG_GYRO_WT:   cfg_prdata = {16'd0, cfg_r.gyro_weight};
      acf_pkg::REG_MEAS_WT:   cfg_prdata = {16'd0, cfg_r.measure_weight};
      acf_pkg::REG_WRAP_EN:   cfg_prdata = {31'd0, cfg_r.wrap_enable};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/acf_ctrl.sv =====
// ----------------------------------------------------------------------------
// acf_ctrl
// sequencer for the filter datapath and owner of the result valid flag
// ----------------------------------------------------------------------------
module acf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  acf_pkg::acf_status_t  status,
  output acf_pkg::acf_cmd_t     cmd
);

  acf_pkg::acf_state_t state_r;
  acf_pkg::acf_state_t state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = acf_pkg::ST_RATE;
        end
      end
      acf_pkg::ST_RATE: state_nxt = acf_pkg::ST_PRED;
      acf_pkg::ST_PRED: begin
        if (status.is_fuse) begin
          state_nxt = acf_pkg::ST_GYRO;
        end else if (out_free) begin
          state_nxt = acf_pkg::ST_IDLE;
        end
      end
      acf_pkg::ST_GYRO: state_nxt = acf_pkg::ST_MEAS;
      acf_pkg::ST_MEAS: state_nxt = acf_pkg::ST_BLEND;
      acf_pkg::ST_BLEND: begin
        if (out_free) begin
          state_nxt = acf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = acf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      acf_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      acf_pkg::ST_RATE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = acf_pkg::MUL_RATE;
      end
      acf_pkg::ST_PRED: begin
        cmd.pred_load = 1'b1;
        cmd.res_load  = !status.is_fuse && out_free;
        cmd.res_sel   = acf_pkg::RES_PRED;
      end
      acf_pkg::ST_GYRO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = acf_pkg::MUL_GYRO;
      end
      acf_pkg::ST_MEAS: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = acf_pkg::MUL_MEAS;
        cmd.acc_load = 1'b1;
      end
      acf_pkg::ST_BLEND: begin
        cmd.res_load = out_free;
        cmd.res_sel  = acf_pkg::RES_BLEND;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/acf_datapath.sv =====
// ----------------------------------------------------------------------------
// acf_datapath
// shared multiplier, prediction, blend and estimate / result registers
// ----------------------------------------------------------------------------
module acf_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  acf_pkg::acf_cfg_t     cfg,
  input  acf_pkg::acf_cmd_t     cmd,
  input  logic [1:0]            in_command,
  input  logic [15:0]           in_measured_angle,
  input  logic [15:0]           in_angle_rate,
  output logic [15:0]           out_estimate,
  output acf_pkg::acf_status_t  status
);

  logic [1:0]                                cmd_r;
  logic signed [acf_pkg::ANG_W-1:0]          meas_r;
  logic signed [acf_pkg::ANG_W-1:0]          rate_r;
  logic signed [acf_pkg::ANG_W-1:0]          est_r;
  logic signed [acf_pkg::ANG_W-1:0]          est_nxt;
  logic signed [acf_pkg::ANG_W-1:0]          pred_r;
  logic signed [acf_pkg::ANG_W-1:0]          pred_nxt;
  logic [acf_pkg::ANG_W-1:0]                 res_r;
  logic signed [33:0]                        prod_r;
  logic signed [33:0]                        prod_nxt;
  logic signed [33:0]                        acc_r;
  logic signed [acf_pkg::MEAS_W-1:0]         mul_a;
  logic signed [16:0]                        mul_b;
  logic signed [acf_pkg::MEAS_W-1:0]         meas_adj;
  logic signed [acf_pkg::WIDE_W-1:0]         step;
  logic signed [acf_pkg::WIDE_W-1:0]         pred_sum;
  logic signed [acf_pkg::PROD_W-1:0]         blend_sum;
  logic signed [acf_pkg::WIDE_W-1:0]         blend_rnd;
  logic signed [acf_pkg::ANG_W-1:0]          blend_val;

  // prediction from the rate product
  assign step     = acf_pkg::round_q12({{2{prod_r[33]}}, prod_r});
  assign pred_sum = {{(acf_pkg::WIDE_W-acf_pkg::ANG_W){est_r[acf_pkg::ANG_W-1]}}, est_r} + step;
  assign pred_nxt = acf_pkg::sat16(acf_pkg::wrap_once(pred_sum, cfg.wrap_enable));

  assign meas_adj = acf_pkg::meas_adjust(meas_r, pred_r, cfg.wrap_enable);

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      acf_pkg::MUL_RATE: begin
        mul_a = {rate_r[acf_pkg::ANG_W-1], rate_r};
        mul_b = {1'b0, cfg.time_step};
      end
      acf_pkg::MUL_GYRO: begin
        mul_a = {pred_r[acf_pkg::ANG_W-1], pred_r};
        mul_b = {1'b0, cfg.gyro_weight};
      end
      acf_pkg::MUL_MEAS: begin
        mul_a = meas_adj;
        mul_b = {1'b0, cfg.measure_weight};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // blend of the two weighted terms
  assign blend_sum = {{2{acc_r[33]}}, acc_r} + {{2{prod_r[33]}}, prod_r};
  assign blend_rnd = acf_pkg::round_q12(blend_sum);
  assign blend_val = acf_pkg::sat16(acf_pkg::wrap_once(blend_rnd, cfg.wrap_enable));

  always_comb begin
    case (cmd.res_sel)
      acf_pkg::RES_PRED:  est_nxt = (cmd_r == acf_pkg::CMD_CLEAR) ? '0 : pred_nxt;
      acf_pkg::RES_BLEND: est_nxt = blend_val;
      default:            est_nxt = pred_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
    end else if (cmd.res_load) begin
      est_r <= est_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r  <= in_command;
      meas_r <= in_measured_angle;
      rate_r <= in_angle_rate;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end
    if (cmd.pred_load) begin
      pred_r <= pred_nxt;
    end
    if (cmd.res_load) begin
      res_r <= est_nxt;
    end
  end

  assign out_estimate    = res_r;
  assign status.is_fuse  = (cmd_r == acf_pkg::CMD_FUSE);
  assign status.estimate = est_r;

endmodule

// ===== hw/rtl/angle_complementary_filter.sv =====
// predict and clear load their result in the predict state, fuse in the blend state
// one request at a time: a new item is accepted only when the sequencer is back in idle
// the single shared 17x17 multiplier is used once for predict and three times for fuse
// a pending result blocks completion of the next item only, not its acceptance
// reset (rst_n low, synchronous): estimate zero, registers to defaults, no result pending
// ----------------------------------------------------------------------------
// angle_complementary_filter
// gyro / measurement complementary filter on q3.12 radians with optional
// wrapping into minus pi to pi and apb configuration
// ----------------------------------------------------------------------------
module angle_complementary_filter (
  input  logic        clk,
  input  logic        rst_n,
  // input request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] measured_angle, [31:16] angle_rate
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] estimate
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "angle_complementary_filter_assert.svh"

  acf_pkg::acf_cfg_t    cfg;      // live register values
  acf_pkg::acf_cmd_t    dp_cmd;   // sequencer to datapath
  acf_pkg::acf_status_t dp_stat;  // datapath to sequencer

  // registers: time_step, gyro_weight, measure_weight, wrap_enable at 0, 4, 8, c
  acf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer: idle, rate multiply, predict, then for fuse gyro and measurement
  // multiplies and the blend; result lands in the output register
  acf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (dp_stat),
    .cmd        (dp_cmd)
  );

  // datapath: shared multiplier, rounding, wrap and saturation, estimate state
  acf_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (dp_cmd),
    .in_command        (in_tuser),
    .in_measured_angle (in_tdata[15:0]),
    .in_angle_rate     (in_tdata[31:16]),
    .out_estimate      (out_tdata),
    .status            (dp_stat)
  );

  // one request in flight: acceptance takes the block busy
  `ACF_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  // a result is only written into a free output slot
  `ACF_ASSERT_IMP(a_no_overwrite, dp_cmd.res_load, !out_tvalid || out_tready)
  // after each result load, the presented result matches the stored estimate
  `ACF_ASSERT_NXT(a_result_is_state, dp_cmd.res_load, out_tdata == dp_stat.estimate)

endmodule
